// ===== sv/mex_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mex_pkg;

	localparam int MEX_WORD_WIDTH      = 32;
	localparam int MEX_CFG_INDEX_WIDTH = 2;

	localparam logic [MEX_CFG_INDEX_WIDTH-1:0] MEX_REG_EXPONENT = 2'd0;
	localparam logic [MEX_CFG_INDEX_WIDTH-1:0] MEX_REG_MODULUS  = 2'd1;

	typedef enum logic [2:0] {
		MEX_IDLE,
		MEX_REDUCE,
		MEX_SQUARE,
		MEX_MULT,
		MEX_DONE
	} mex_state_t;

endpackage

`default_nettype wire

// ===== sv/mex_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add modular multiplier: (a * b) mod m, one bit of b per cycle,
// msb first. Requires a < m; b may be any word (b = x with a = 1 gives x mod m).
module mex_mulmod #(
	parameter int WORD_WIDTH = mex_pkg::MEX_WORD_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [WORD_WIDTH-1:0] a,
	input  wire logic [WORD_WIDTH-1:0] b,
	input  wire logic [WORD_WIDTH-1:0] m,
	output logic                       done,
	output logic [WORD_WIDTH-1:0]      result
);

	localparam int CntW = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;

	logic [WORD_WIDTH-1:0] a_q, b_q, m_q, acc_q;
	logic [CntW-1:0]       cnt_q;
	logic                  busy_q, done_q;

	logic [WORD_WIDTH:0]   dbl, red1, sum, red2;

	always_comb begin
		dbl  = {acc_q, 1'b0};
		red1 = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum  = red1 + (b_q[WORD_WIDTH-1] ? {1'b0, a_q} : '0);
		red2 = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(WORD_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= red2[WORD_WIDTH-1:0];
			b_q   <= {b_q[WORD_WIDTH-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    ciphertext
// out       out  out_valid / out_ready  plaintext
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data (0 exponent, 1 modulus)
//
// Each item reduces the ciphertext mod m, then squares once per exponent bit, msb first,
// and multiplies by the base for each set bit; every step runs through the one shared
// multiplier, one modular product at a time.
// A modulus below 2 skips the multiplier and yields 0.
// in_ready is high only while idle. A finished result waits in the output register;
// the next item is taken once the result is written there. No clearing pass after reset.
module modular_exponentiation_core #(
	parameter int WORD_WIDTH = mex_pkg::MEX_WORD_WIDTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic [WORD_WIDTH-1:0]                   ciphertext,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic [WORD_WIDTH-1:0]                        plaintext,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [mex_pkg::MEX_CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [WORD_WIDTH-1:0]                   cfg_data
);

	localparam int BitW = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
	localparam logic [WORD_WIDTH-1:0] One = {{(WORD_WIDTH-1){1'b0}}, 1'b1};

	mex_pkg::mex_state_t state_q, state_d;

	logic [WORD_WIDTH-1:0] exponent_q, modulus_q;
	logic [WORD_WIDTH-1:0] base_q, acc_q, plaintext_q;
	logic [BitW-1:0]       bit_q;
	logic                  out_valid_q;

	logic                  mul_start, mul_done;
	logic [WORD_WIDTH-1:0] mul_a, mul_b, mul_result;

	logic                  acc_we, base_we, bit_init, bit_dec, out_we;
	logic [WORD_WIDTH-1:0] acc_d;

	mex_mulmod #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.m     (modulus_q),
		.done  (mul_done),
		.result(mul_result)
	);

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = mul_result;
		mul_b     = mul_result;
		acc_we    = 1'b0;
		acc_d     = mul_result;
		base_we   = 1'b0;
		bit_init  = 1'b0;
		bit_dec   = 1'b0;
		out_we    = 1'b0;
		case (state_q)
			mex_pkg::MEX_IDLE: begin
				if (in_valid) begin
					if (modulus_q < WORD_WIDTH'(2)) begin
						acc_we  = 1'b1;
						acc_d   = '0;
						state_d = mex_pkg::MEX_DONE;
					end else begin
						// base = ciphertext mod m, as 1 * ciphertext
						mul_start = 1'b1;
						mul_a     = One;
						mul_b     = ciphertext;
						state_d   = mex_pkg::MEX_REDUCE;
					end
				end
			end
			mex_pkg::MEX_REDUCE: begin
				if (mul_done) begin
					base_we   = 1'b1;
					bit_init  = 1'b1;
					mul_start = 1'b1;
					mul_a     = One;
					mul_b     = One;
					state_d   = mex_pkg::MEX_SQUARE;
				end
			end
			mex_pkg::MEX_SQUARE: begin
				if (mul_done) begin
					acc_we = 1'b1;
					if (exponent_q[bit_q]) begin
						mul_start = 1'b1;
						mul_b     = base_q;
						state_d   = mex_pkg::MEX_MULT;
					end else if (bit_q == '0) begin
						state_d = mex_pkg::MEX_DONE;
					end else begin
						bit_dec   = 1'b1;
						mul_start = 1'b1;
					end
				end
			end
			mex_pkg::MEX_MULT: begin
				if (mul_done) begin
					acc_we = 1'b1;
					if (bit_q == '0) begin
						state_d = mex_pkg::MEX_DONE;
					end else begin
						bit_dec   = 1'b1;
						mul_start = 1'b1;
						state_d   = mex_pkg::MEX_SQUARE;
					end
				end
			end
			mex_pkg::MEX_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_we  = 1'b1;
					state_d = mex_pkg::MEX_IDLE;
				end
			end
			default: begin
				state_d = mex_pkg::MEX_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mex_pkg::MEX_IDLE;
			out_valid_q <= 1'b0;
			exponent_q  <= One;
			modulus_q   <= WORD_WIDTH'(2);
		end else begin
			state_q <= state_d;
			if (out_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					mex_pkg::MEX_REG_EXPONENT: exponent_q <= cfg_data;
					mex_pkg::MEX_REG_MODULUS:  modulus_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_q <= acc_d;
		end
		if (base_we) begin
			base_q <= mul_result;
		end
		if (bit_init) begin
			bit_q <= BitW'(WORD_WIDTH - 1);
		end else if (bit_dec) begin
			bit_q <= bit_q - 1'b1;
		end
		if (out_we) begin
			plaintext_q <= acc_q;
		end
	end

	assign in_ready  = (state_q == mex_pkg::MEX_IDLE);
	assign out_valid = out_valid_q;
	assign plaintext = plaintext_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
